// File: design/mips_integer_alu_execute_defines.svh
// Assertion macros shared by the execute block
`ifndef MIPS_INTEGER_ALU_EXECUTE_DEFINES_SVH
`define MIPS_INTEGER_ALU_EXECUTE_DEFINES_SVH

// Check that a condition implies a consequence on the same edge
`define MIAE_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge
`define MIAE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/miae_pkg.sv
`timescale 1ns / 1ps
package miae_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_W    = $clog2(NUM_REGS);

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_ADDI  = 5'd1,  OP_ADDIU = 5'd2,  OP_ADDU  = 5'd3,
        OP_SUB   = 5'd4,  OP_SUBU  = 5'd5,  OP_DIV   = 5'd6,  OP_DIVU  = 5'd7,
        OP_MULT  = 5'd8,  OP_MULTU = 5'd9,  OP_SLL   = 5'd10, OP_SLLV  = 5'd11,
        OP_SRA   = 5'd12, OP_SRAV  = 5'd13, OP_SRL   = 5'd14, OP_SRLV  = 5'd15,
        OP_AND   = 5'd16, OP_ANDI  = 5'd17, OP_NOR   = 5'd18, OP_OR    = 5'd19,
        OP_ORI   = 5'd20, OP_XOR   = 5'd21, OP_XORI  = 5'd22, OP_SLT   = 5'd23,
        OP_SLTI  = 5'd24, OP_SLTIU = 5'd25, OP_SLTU  = 5'd26
    } t_op;

    typedef struct packed {
        logic [4:0]       op;
        logic [REG_W-1:0] src_a_index;
        logic [REG_W-1:0] src_b_index;
        logic [REG_W-1:0] dest_index;
        logic [4:0]       shift_amount;
        logic [15:0]      immediate;
    } t_req;

    typedef struct packed {
        logic             reg_write;
        logic [REG_W-1:0] write_index;
        logic [31:0]      write_value;
        logic             overflow;
        logic [31:0]      hi_value;
        logic [31:0]      lo_value;
    } t_rsp;

    // Register file write port
    typedef struct packed {
        logic             en;
        logic [REG_W-1:0] idx;
        logic [31:0]      data;
    } t_rf_wr;

endpackage

// File: design/miae_regfile.sv
`timescale 1ns / 1ps
module miae_regfile
    import miae_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REG_W-1:0] i_rd_a_idx,
    input  logic [REG_W-1:0] i_rd_b_idx,
    input  t_rf_wr           i_wr,
    output logic [31:0]      o_rd_a,
    output logic [31:0]      o_rd_b
);
    logic [31:0]    r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]    r_a, r_b;
    logic           r_a_ok, r_b_ok;

    // Write one entry; valid bits stand for the reset clear
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    // Registered reads, entry zero and unwritten entries read zero
    always_ff @(posedge i_clk) begin
        r_a    <= r_mem[i_rd_a_idx];
        r_b    <= r_mem[i_rd_b_idx];
        r_a_ok <= r_valid[i_rd_a_idx] && (i_rd_a_idx != '0);
        r_b_ok <= r_valid[i_rd_b_idx] && (i_rd_b_idx != '0);
    end

    assign o_rd_a = r_a_ok ? r_a : 32'd0;
    assign o_rd_b = r_b_ok ? r_b : 32'd0;
endmodule

// File: design/miae_muldiv.sv
`timescale 1ns / 1ps
module miae_muldiv
    import miae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_div,
    input  logic        i_signed,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_hi,
    output logic [31:0] o_lo
);
    // Multiply: 33x33 signed product in one registered step.
    // Divide: restoring, one quotient bit per cycle over magnitudes.
    logic        r_busy, r_neg_q, r_neg_r, r_done;
    logic        r_div_last;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo, r_rem, r_dsr, r_hi, r_lo;
    logic [31:0] abs_a, abs_b;
    logic [32:0] trial;
    logic signed [65:0] prod;

    assign abs_a = (i_signed && i_a[31]) ? (32'd0 - i_a) : i_a;
    assign abs_b = (i_signed && i_b[31]) ? (32'd0 - i_b) : i_b;
    assign prod  = $signed({i_signed & i_a[31], i_a}) * $signed({i_signed & i_b[31], i_b});
    assign trial = {r_rem, r_quo[31]} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !i_is_div) begin
                r_hi   <= prod[63:32];
                r_lo   <= prod[31:0];
                r_done <= 1'b1;
            end else if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 6'd32;
                r_quo   <= abs_a;
                r_rem   <= 32'd0;
                r_dsr   <= abs_b;
                r_neg_q <= i_signed && (i_a[31] ^ i_b[31]);
                r_neg_r <= i_signed && i_a[31];
            end else if (r_busy) begin
                // Shift in one quotient bit
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Apply signs after the last step
    assign o_done = r_done;
    always_comb begin
        if (r_div_last) begin
            o_lo = r_neg_q ? (32'd0 - r_quo) : r_quo;
            o_hi = r_neg_r ? (32'd0 - r_rem) : r_rem;
        end else begin
            o_lo = r_lo;
            o_hi = r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_last <= 1'b0;
        end else if (i_start) begin
            r_div_last <= i_is_div;
        end
    end
endmodule

// File: design/mips_integer_alu_execute.sv
`timescale 1ns / 1ps
// Executes one R3000 integer ALU instruction per request against a 32 x 32
// register file held in a synchronous memory, plus HI and LO. A request is
// taken, its operands are read from the memory, then the result is written
// back and presented on the output register. Multiply, and divide by a
// nonzero divisor, run in the shared multiply/divide unit (one quotient bit
// per cycle for divide). Register 0 reads as zero.
module mips_integer_alu_execute
    import miae_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
`include "mips_integer_alu_execute_defines.svh"

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MD, S_OUT} t_state;

    t_state      r_state;
    t_req        r_req;
    t_rsp        r_rsp;
    logic [31:0] r_hi, r_lo;
    logic [31:0] rs, rt;
    t_rf_wr      wr;
    logic        md_start, md_done, md_div, md_signed;
    logic [31:0] md_hi, md_lo;

    logic [31:0] simm, zimm, r_sum, val, b_add;
    logic [4:0]  vsh;
    logic        wr_en, ovf, use_rt;
    t_op         op;

    miae_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd_a_idx(i_req.src_a_index), .i_rd_b_idx(i_req.src_b_index),
        .i_wr(wr), .o_rd_a(rs), .o_rd_b(rt)
    );

    assign op        = t_op'(r_req.op);
    assign md_div    = (op == OP_DIV) || (op == OP_DIVU);
    assign md_signed = (op == OP_DIV) || (op == OP_MULT);
    assign md_start  = (r_state == S_READ) &&
                       (op == OP_MULT || op == OP_MULTU || ((op == OP_DIV || op == OP_DIVU)
                        && rt != 32'd0));

    miae_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(md_start), .i_is_div(md_div),
        .i_signed(md_signed), .i_a(rs), .i_b(rt),
        .o_done(md_done), .o_hi(md_hi), .o_lo(md_lo)
    );

    // Compute the simple result from the fresh operands
    assign simm  = {{16{r_req.immediate[15]}}, r_req.immediate};
    assign zimm  = {16'd0, r_req.immediate};
    assign vsh   = rs[4:0];
    assign b_add = (op == OP_ADDI) ? simm : rt;
    assign r_sum = (op == OP_SUB) ? (rs - rt) : (rs + b_add);

    always_comb begin
        wr_en  = 1'b1;
        ovf    = 1'b0;
        use_rt = 1'b0;
        val    = 32'd0;
        unique case (op)
            OP_ADD, OP_ADDI: begin
                val    = r_sum;
                ovf    = ~(rs[31] ^ b_add[31]) & (rs[31] ^ r_sum[31]);
                use_rt = (op == OP_ADDI);
            end
            OP_SUB: begin
                val = r_sum;
                ovf = (rs[31] ^ rt[31]) & (rs[31] ^ r_sum[31]);
            end
            OP_ADDIU: begin val = rs + simm; use_rt = 1'b1; end
            OP_ADDU:  val = rs + rt;
            OP_SUBU:  val = rs - rt;
            OP_DIV, OP_DIVU: wr_en = 1'b0;
            OP_MULT, OP_MULTU: val = md_lo;
            OP_SLL:   val = rt << r_req.shift_amount;
            OP_SLLV:  val = rt << vsh;
            OP_SRA:   val = 32'($signed(rt) >>> r_req.shift_amount);
            OP_SRAV:  val = 32'($signed(rt) >>> vsh);
            OP_SRL:   val = rt >> r_req.shift_amount;
            OP_SRLV:  val = rt >> vsh;
            OP_AND:   val = rs & rt;
            OP_ANDI:  begin val = rs & zimm; use_rt = 1'b1; end
            OP_NOR:   val = ~(rs | rt);
            OP_OR:    val = rs | rt;
            OP_ORI:   begin val = rs | zimm; use_rt = 1'b1; end
            OP_XOR:   val = rs ^ rt;
            OP_XORI:  begin val = rs ^ zimm; use_rt = 1'b1; end
            OP_SLT:   val = {31'd0, $signed(rs) < $signed(rt)};
            OP_SLTI:  begin val = {31'd0, $signed(rs) < $signed(simm)}; use_rt = 1'b1; end
            OP_SLTIU: begin val = {31'd0, rs < simm}; use_rt = 1'b1; end
            OP_SLTU:  val = {31'd0, rs < rt};
            default:  wr_en = 1'b0;
        endcase
        if (ovf) begin
            wr_en = 1'b0;
        end
    end

    // Write back the final result
    logic [REG_W-1:0] widx;
    logic             fin_simple, fin;
    logic             wr_go;
    assign widx       = use_rt ? r_req.src_b_index : r_req.dest_index;
    assign fin_simple = (r_state == S_READ) && !md_start;
    assign fin        = fin_simple || (r_state == S_MD && md_done);
    assign wr_go      = wr_en && (widx != '0);
    assign wr.en      = fin && wr_go;
    assign wr.idx     = widx;
    assign wr.data    = val;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = r_rsp;

    // Sequence one request at a time; hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hi    <= 32'd0;
            r_lo    <= 32'd0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_req   <= i_req;
                    r_state <= S_READ;
                end
                S_READ: r_state <= md_start ? S_MD : S_OUT;
                S_MD:   if (md_done) r_state <= S_OUT;
                S_OUT:  if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (fin) begin
                r_rsp.reg_write   <= wr_go;
                r_rsp.write_index <= wr_go ? widx : '0;
                r_rsp.write_value <= wr_go ? val : 32'd0;
                r_rsp.overflow    <= ovf;
                r_rsp.hi_value    <= md_done ? md_hi : r_hi;
                r_rsp.lo_value    <= md_done ? md_lo : r_lo;
                if (md_done) begin
                    r_hi <= md_hi;
                    r_lo <= md_lo;
                end
            end
        end
    end

    `MIAE_ASSERT_IMP(a_no_wr_r0, i_clk, i_rst_n, wr.en, wr.idx != '0, "write to r0")
    `MIAE_ASSERT_IMP(a_ovf_nowr, i_clk, i_rst_n, fin && ovf, !wr.en, "write on overflow")
    `MIAE_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, fin, o_valid, "result not shown")
endmodule

// File: sim/tb_mips_integer_alu_execute.sv
`timescale 1ns / 1ps
module tb_mips_integer_alu_execute;
    import miae_pkg::*;

    // Predicts ALU results and holds them until the block returns them
    class alu_scoreboard;
        logic [31:0] gpr [NUM_REGS];
        logic [31:0] hi_q;
        logic [31:0] lo_q;
        t_rsp        pending_q[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
            hi_q = '0;
            lo_q = '0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [31:0] rd_reg(logic [4:0] idx);
            return (idx == 0) ? 32'd0 : gpr[idx];
        endfunction

        // Compute the effect of one accepted request
        function void note_request(t_req r);
            logic [31:0] rs, rt, simm, zimm, b, res;
            logic [4:0]  widx, vsh;
            logic        wr, ovf;
            logic [63:0] prod;
            t_rsp        e;
            rs   = rd_reg(r.src_a_index);
            rt   = rd_reg(r.src_b_index);
            simm = {{16{r.immediate[15]}}, r.immediate};
            zimm = {16'd0, r.immediate};
            vsh  = rs[4:0];
            wr   = 1'b1;
            ovf  = 1'b0;
            widx = r.dest_index;
            res  = '0;
            case (r.op)
                OP_ADD, OP_ADDI: begin
                    b = (r.op == OP_ADDI) ? simm : rt;
                    res = rs + b;
                    ovf = (~(rs[31] ^ b[31])) & (rs[31] ^ res[31]);
                    if (r.op == OP_ADDI) widx = r.src_b_index;
                end
                OP_SUB: begin
                    res = rs - rt;
                    ovf = (rs[31] ^ rt[31]) & (rs[31] ^ res[31]);
                end
                OP_ADDIU: begin widx = r.src_b_index; res = rs + simm; end
                OP_ADDU:  res = rs + rt;
                OP_SUBU:  res = rs - rt;
                OP_DIV: begin
                    wr = 1'b0;
                    if (rt != 0) begin
                        if (rs == 32'h8000_0000 && rt == 32'hFFFF_FFFF) begin
                            lo_q = 32'h8000_0000;
                            hi_q = '0;
                        end else begin
                            lo_q = $signed(rs) / $signed(rt);
                            hi_q = $signed(rs) % $signed(rt);
                        end
                    end
                end
                OP_DIVU: begin
                    wr = 1'b0;
                    if (rt != 0) begin
                        lo_q = rs / rt;
                        hi_q = rs % rt;
                    end
                end
                OP_MULT, OP_MULTU: begin
                    if (r.op == OP_MULT)
                        prod = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
                    else
                        prod = {32'd0, rs} * {32'd0, rt};
                    lo_q = prod[31:0];
                    hi_q = prod[63:32];
                    res  = lo_q;
                end
                OP_SLL:  res = rt << r.shift_amount;
                OP_SLLV: res = rt << vsh;
                OP_SRA:  res = $signed(rt) >>> r.shift_amount;
                OP_SRAV: res = $signed(rt) >>> vsh;
                OP_SRL:  res = rt >> r.shift_amount;
                OP_SRLV: res = rt >> vsh;
                OP_AND:  res = rs & rt;
                OP_ANDI: begin widx = r.src_b_index; res = rs & zimm; end
                OP_NOR:  res = ~(rs | rt);
                OP_OR:   res = rs | rt;
                OP_ORI:  begin widx = r.src_b_index; res = rs | zimm; end
                OP_XOR:  res = rs ^ rt;
                OP_XORI: begin widx = r.src_b_index; res = rs ^ zimm; end
                OP_SLT:  res = ($signed(rs) < $signed(rt)) ? 32'd1 : 32'd0;
                OP_SLTI: begin
                    widx = r.src_b_index;
                    res = ($signed(rs) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                OP_SLTIU: begin widx = r.src_b_index; res = (rs < simm) ? 32'd1 : 32'd0; end
                OP_SLTU: res = (rs < rt) ? 32'd1 : 32'd0;
                default: wr = 1'b0;
            endcase
            if (ovf || widx == 0) wr = 1'b0;
            if (wr) gpr[widx] = res;
            e.reg_write   = wr;
            e.write_index = wr ? widx : '0;
            e.write_value = wr ? res : '0;
            e.overflow    = ovf;
            e.hi_value    = hi_q;
            e.lo_value    = lo_q;
            pending_q.push_back(e);
        endfunction

        // Compare one returned result with the oldest prediction
        function void check_result(t_rsp a);
            t_rsp e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (a.reg_write !== e.reg_write) begin
                $error("reg_write exp %0d got %0d", e.reg_write, a.reg_write); errors++;
            end
            if (a.write_index !== e.write_index) begin
                $error("write_index exp %0d got %0d", e.write_index, a.write_index); errors++;
            end
            if (a.write_value !== e.write_value) begin
                $error("write_value exp %h got %h", e.write_value, a.write_value); errors++;
            end
            if (a.overflow !== e.overflow) begin
                $error("overflow exp %0d got %0d", e.overflow, a.overflow); errors++;
            end
            if (a.hi_value !== e.hi_value) begin
                $error("hi_value exp %h got %h", e.hi_value, a.hi_value); errors++;
            end
            if (a.lo_value !== e.lo_value) begin
                $error("lo_value exp %h got %h", e.lo_value, a.lo_value); errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_REQS = 1800;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    alu_scoreboard sb;
    int  cycle_count;
    int  sent;
    bit  hold_rx;
    bit  hold_done;

    mips_integer_alu_execute u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Note accepted requests and check accepted results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_req);
            if (o_valid && !i_stall) sb.check_result(o_rsp);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall: random gaps, one long hold while the sender waits
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                for (int k = 0; k < 300; k++) @(negedge i_clk);
                hold_rx = 1'b0;
                hold_done = 1'b1;
            end
            n = (sent > 1300 && sent < 1500) ? 0 : gap_len();
            if (n == 0) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                for (int k = 1; k < n; k++) @(negedge i_clk);
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_req(t_req r);
        i_req   <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            i_req   <= t_req'(($bits(t_req))'({$urandom, $urandom}));
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic t_req make_req(logic [4:0] op, logic [4:0] a, logic [4:0] b,
                                      logic [4:0] d, logic [15:0] imm);
        t_req r;
        r.op = op;
        r.src_a_index = a;
        r.src_b_index = b;
        r.dest_index = d;
        r.shift_amount = 5'($urandom_range(0, 31));
        r.immediate = imm;
        return r;
    endfunction

    function automatic logic [15:0] rand_imm();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random request: mostly defined ops, registers biased to a small working set
    function automatic t_req rand_req();
        t_req r;
        r = t_req'(($bits(t_req))'({$urandom, $urandom}));
        if ($urandom_range(0, 19) == 0) r.op = 5'($urandom_range(27, 31));
        else r.op = 5'($urandom_range(OP_ADD, OP_SLTU));
        if ((r.op == OP_DIV || r.op == OP_DIVU) && $urandom_range(0, 3) != 0)
            r.op = 5'($urandom_range(OP_MULT, OP_SLTU));
        if ($urandom_range(0, 3) != 0) begin
            r.src_a_index = 5'($urandom_range(0, 7));
            r.src_b_index = 5'($urandom_range(0, 7));
            r.dest_index  = 5'($urandom_range(0, 7));
        end
        r.immediate = rand_imm();
        return r;
    endfunction

    initial begin
        t_req r;
        sb = new();
        cycle_count = 0;
        sent = 0;
        hold_rx = 1'b0;
        hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Seed registers with extremes: 1 = MIN, 2 = -1, 3 = MAX, 4 = 1, 5 = 0xFFFF0000
        send_req(make_req(OP_ORI,   0, 4, 0, 16'h0001));
        send_req(make_req(OP_ADDIU, 0, 2, 0, 16'hFFFF));
        send_req(make_req(OP_SLL,   0, 1, 1, 16'h0000));
        r = make_req(OP_SLL, 0, 4, 1, 0); r.shift_amount = 31;
        send_req(r);
        send_req(make_req(OP_SRL,   0, 2, 3, 0));
        r = make_req(OP_SRL, 0, 2, 3, 0); r.shift_amount = 1;
        send_req(r);
        r = make_req(OP_SLL, 0, 2, 5, 0); r.shift_amount = 16;
        send_req(r);
        // Signed overflow on add, addi and sub
        send_req(make_req(OP_ADD,  3, 4, 6, 0));
        send_req(make_req(OP_ADDI, 3, 7, 0, 16'h0001));
        send_req(make_req(OP_SUB,  1, 4, 6, 0));
        // Divide by zero, minimum by minus one, multiplies at the extremes
        send_req(make_req(OP_DIV,  1, 0, 0, 0));
        send_req(make_req(OP_DIV,  1, 2, 0, 0));
        send_req(make_req(OP_DIVU, 2, 3, 0, 0));
        send_req(make_req(OP_MULT, 1, 1, 7, 0));
        send_req(make_req(OP_MULTU, 2, 2, 7, 0));
        // Arithmetic shift of negative, variable shift, sltiu with negative immediate
        r = make_req(OP_SRA, 0, 1, 8, 0); r.shift_amount = 31;
        send_req(r);
        send_req(make_req(OP_SRAV, 2, 1, 8, 0));
        send_req(make_req(OP_SLTIU, 4, 9, 0, 16'hFFFF));
        send_req(make_req(OP_SLTI,  1, 9, 0, 16'h8000));
        send_req(make_req(OP_NOR,   0, 0, 10, 0));
        // Write to register zero, unused op code
        send_req(make_req(OP_ADDU,  2, 2, 0, 0));
        send_req(make_req(5'd31,    2, 3, 4, 16'hFFFF));

        // Random part with gaps; a long receiver hold partway through
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == 700) hold_rx = 1'b1;
            if (i > 700 && i < 760) send_req(rand_req());
            else begin
                idle_gap((i % 200 < 40) ? 0 : gap_len());
                send_req(rand_req());
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Executed %0d requests, checked %0d results, incl. overflow, divide and %s",
                 sent, sb.checked, hold_done ? "a long output hold" : "no long hold");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/miae_pkg.sv
design/miae_regfile.sv
design/miae_muldiv.sv
design/mips_integer_alu_execute.sv
sim/tb_mips_integer_alu_execute.sv
